FILE: src/wav_data_chunk_extractor_top_assert.svh
// ----------------------------------------------------------------------------
// WAV data chunk extractor assertion macros
// Helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WAV_DATA_CHUNK_EXTRACTOR_TOP_ASSERT_SVH
`define WAV_DATA_CHUNK_EXTRACTOR_TOP_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define WDCE_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (prop)) \
    else $error(msg);

// The condition must never be true outside reset.
`define WDCE_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) !(cond)) \
    else $error(msg);

`endif

FILE: src/wdce_pkg.sv
// ----------------------------------------------------------------------------
// WAV data chunk extractor package
// Transfer types, parser codes and constants shared by the extractor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wdce_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [15:0] sample;
    logic              last;
  } out_item_t;

  localparam logic [2:0] PH_RIFF   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_OK     = 2'd1;
  localparam logic [1:0] KIND_SHORT  = 2'd2;
  localparam logic [1:0] KIND_NODATA = 2'd3;

  localparam logic [5:0]  MIN_FILE_BYTES   = 6'd44;
  localparam logic [5:0]  RIFF_HEADER_BYTES = 6'd12;
  localparam logic [2:0]  HDR_LAST_INDEX   = 3'd7;
  localparam logic [2:0]  HDR_ID_BYTES     = 3'd4;
  localparam logic [31:0] DATA_ID          = 32'h6461_7461;

  typedef struct packed {
    logic [1:0] wr_count;
    out_item_t  first;
    out_item_t  second;
  } res_pair_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [5:0] byte_count;
  } parse_stat_t;

endpackage

`default_nettype wire

FILE: src/wdce_parser.sv
// ----------------------------------------------------------------------------
// WAV data chunk extractor parser
// Walks the RIFF chunk structure one byte per transfer and forms the samples
// and end-of-file status of each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wdce_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire wdce_pkg::in_item_t in_item,
  output wdce_pkg::res_pair_t    res,
  output wdce_pkg::parse_stat_t  stat
);

  logic [2:0]  phase_r,     phase_nxt;
  logic [5:0]  count_r,     count_nxt;
  logic [2:0]  idx_r,       idx_nxt;
  logic [31:0] id_r,        id_nxt;
  logic [31:0] len_r,       len_nxt;
  logic [32:0] skip_r,      skip_nxt;
  logic [31:0] data_rem_r,  data_rem_nxt;
  logic [7:0]  low_r,       low_nxt;
  logic        low_valid_r, low_valid_nxt;
  logic        found_r,     found_nxt;

  logic [5:0]  count_inc;
  logic [31:0] len_full;
  logic [32:0] skip_dec;
  logic [31:0] data_dec;
  logic        sample_v;
  logic [15:0] sample_val;
  logic [1:0]  status_kind;
  logic [7:0]  b;
  wdce_pkg::out_item_t status_item;
  wdce_pkg::out_item_t sample_item;

  always_comb begin
    b             = in_item.file_byte;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    skip_nxt      = skip_r;
    data_rem_nxt  = data_rem_r;
    low_nxt       = low_r;
    low_valid_nxt = low_valid_r;
    found_nxt     = found_r;
    sample_v      = 1'b0;
    sample_val    = {b, low_r};
    len_full      = {b, len_r[23:0]};
    skip_dec      = (skip_r != 33'd0) ? skip_r - 33'd1 : skip_r;
    data_dec      = (data_rem_r != 32'd0) ? data_rem_r - 32'd1 : data_rem_r;
    count_inc     = (count_r < wdce_pkg::MIN_FILE_BYTES) ? count_r + 6'd1 : count_r;
    count_nxt     = count_inc;

    unique case (phase_r)
      wdce_pkg::PH_RIFF: begin
        if (count_inc >= wdce_pkg::RIFF_HEADER_BYTES) begin
          phase_nxt = wdce_pkg::PH_HEADER;
          idx_nxt   = 3'd0;
        end
      end
      wdce_pkg::PH_HEADER: begin
        if (idx_r < wdce_pkg::HDR_ID_BYTES) begin
          id_nxt = {id_r[23:0], b};
          if (idx_r == 3'd0) begin
            len_nxt = 32'd0;
          end
        end else begin
          unique case (idx_r[1:0])
            2'd0: len_nxt[7:0]   = b;
            2'd1: len_nxt[15:8]  = b;
            2'd2: len_nxt[23:16] = b;
            default: len_nxt[31:24] = b;
          endcase
        end
        idx_nxt = idx_r + 3'd1;
        if (idx_r == wdce_pkg::HDR_LAST_INDEX) begin
          if (id_r == wdce_pkg::DATA_ID) begin
            found_nxt    = 1'b1;
            data_rem_nxt = len_full;
            phase_nxt    = (len_full == 32'd0) ? wdce_pkg::PH_DONE : wdce_pkg::PH_DATA;
          end else begin
            skip_nxt  = {1'b0, len_full} + {32'd0, len_full[0]};
            phase_nxt = (len_full == 32'd0) ? wdce_pkg::PH_HEADER : wdce_pkg::PH_SKIP;
          end
        end
      end
      wdce_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 33'd0) begin
          phase_nxt = wdce_pkg::PH_HEADER;
          idx_nxt   = 3'd0;
        end
      end
      wdce_pkg::PH_DATA: begin
        data_rem_nxt = data_dec;
        if (data_rem_r != 32'd0) begin
          if (low_valid_r) begin
            sample_v      = 1'b1;
            low_valid_nxt = 1'b0;
          end else begin
            low_nxt       = b;
            low_valid_nxt = 1'b1;
          end
        end
        if (data_dec == 32'd0) begin
          phase_nxt     = wdce_pkg::PH_DONE;
          low_valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (count_inc < wdce_pkg::MIN_FILE_BYTES) begin
      status_kind = wdce_pkg::KIND_SHORT;
    end else if (found_nxt) begin
      status_kind = wdce_pkg::KIND_OK;
    end else begin
      status_kind = wdce_pkg::KIND_NODATA;
    end

    status_item.kind   = status_kind;
    status_item.sample = 16'sd0;
    status_item.last   = 1'b1;
    sample_item.kind   = wdce_pkg::KIND_SAMPLE;
    sample_item.sample = sample_val;
    sample_item.last   = !in_item.end_of_file;

    res.wr_count = 2'd0;
    res.first    = sample_item;
    res.second   = status_item;
    if (sample_v) begin
      res.wr_count = in_item.end_of_file ? 2'd2 : 2'd1;
    end else if (in_item.end_of_file) begin
      res.wr_count = 2'd1;
      res.first    = status_item;
    end
    if (!in_fire) begin
      res.wr_count = 2'd0;
    end

    if (in_item.end_of_file) begin
      phase_nxt     = wdce_pkg::PH_RIFF;
      count_nxt     = 6'd0;
      idx_nxt       = 3'd0;
      id_nxt        = 32'd0;
      len_nxt       = 32'd0;
      skip_nxt      = 33'd0;
      data_rem_nxt  = 32'd0;
      low_nxt       = 8'd0;
      low_valid_nxt = 1'b0;
      found_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wdce_pkg::PH_RIFF;
      count_r     <= 6'd0;
      idx_r       <= 3'd0;
      id_r        <= 32'd0;
      len_r       <= 32'd0;
      skip_r      <= 33'd0;
      data_rem_r  <= 32'd0;
      low_r       <= 8'd0;
      low_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      id_r        <= id_nxt;
      len_r       <= len_nxt;
      skip_r      <= skip_nxt;
      data_rem_r  <= data_rem_nxt;
      low_r       <= low_nxt;
      low_valid_r <= low_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  assign stat.phase      = phase_r;
  assign stat.byte_count = count_r;

endmodule

`default_nettype wire

FILE: src/wdce_result_fifo.sv
// ----------------------------------------------------------------------------
// WAV data chunk extractor result queue
// Small queue that takes up to two results per cycle and presents one per
// output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wdce_result_fifo #(
  parameter int ADDR_W = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wdce_pkg::res_pair_t wr,
  input  wire logic                rd,
  output logic                     can_take_two,
  output logic                     not_empty,
  output wdce_pkg::out_item_t      head,
  output logic [ADDR_W:0]          level
);

  localparam int DEPTH = 1 << ADDR_W;

  wdce_pkg::out_item_t mem [DEPTH];

  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W:0]   count_r,  count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ADDR_W'(wr.wr_count);
    rd_ptr_nxt = rd_ptr_r + ADDR_W'(rd);
    count_nxt  = count_r + (ADDR_W + 1)'(wr.wr_count) - (ADDR_W + 1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (wr.wr_count != 2'd0) begin
      mem[wr_ptr_r] <= wr.first;
    end
    if (wr.wr_count == 2'd2) begin
      mem[wr_ptr_r + ADDR_W'(1)] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign can_take_two = (count_r <= (ADDR_W + 1)'(DEPTH - 2));
  assign not_empty    = (count_r != '0);
  assign head         = mem[rd_ptr_r];
  assign level        = count_r;

endmodule

`default_nettype wire

FILE: src/wav_data_chunk_extractor_top.sv
// Output: the results of a byte are written to the result queue when the byte
// is taken, and the queue offers them in order, one per output transfer.
// Throughput: one byte per cycle; input is held off while the result queue has
// fewer than two free entries.
// Reset: synchronous, active low; it clears the parser and empties the queue.
// ----------------------------------------------------------------------------
// WAV data chunk extractor top level
// Extracts PCM16 samples from the first data chunk of a WAV byte stream and
// reports a status at the end of each file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "wav_data_chunk_extractor_top_assert.svh"

module wav_data_chunk_extractor_top #(
  parameter int RES_FIFO_AW = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wdce_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wdce_pkg::out_item_t      out_data
);

  logic                   in_fire;
  logic                   out_fire;
  logic                   can_take_two;
  logic [RES_FIFO_AW:0]   fifo_level;
  wdce_pkg::res_pair_t    res;
  wdce_pkg::parse_stat_t  stat;

  assign in_stall = !can_take_two;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  wdce_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .res     (res),
    .stat    (stat)
  );

  wdce_result_fifo #(
    .ADDR_W (RES_FIFO_AW)
  ) u_result_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr           (res),
    .rd           (out_fire),
    .can_take_two (can_take_two),
    .not_empty    (out_valid),
    .head         (out_data),
    .level        (fifo_level)
  );

  `WDCE_ASSERT_NEVER(a_fifo_no_overflow, clk, rst_n,
    fifo_level > (RES_FIFO_AW + 1)'(1 << RES_FIFO_AW), "result queue overflow")
  `WDCE_ASSERT(a_status_is_last, clk, rst_n,
    out_valid && out_data.kind != wdce_pkg::KIND_SAMPLE |-> out_data.last,
    "status result not marked last")
  `WDCE_ASSERT(a_eof_restarts, clk, rst_n,
    in_fire && in_data.end_of_file |=> stat.phase == wdce_pkg::PH_RIFF &&
    stat.byte_count == 6'd0, "parser not restarted after end of file")
  `WDCE_ASSERT_NEVER(a_count_saturates, clk, rst_n,
    stat.byte_count > wdce_pkg::MIN_FILE_BYTES, "byte count beyond saturation")

endmodule

`default_nettype wire

FILE: bench/wav_data_chunk_extractor_top_tb.sv
// ----------------------------------------------------------------------------
// WAV data chunk extractor testbench
// Feeds WAV byte streams through the extractor with random gaps on the input
// and random stalls on the output. The streams include well-formed files,
// short files, files without a data chunk, cut headers and oversized chunks.
// A parser model in the bench predicts every sample and status transfer, and
// the results are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wav_data_chunk_extractor_top_tb;

  localparam int ITEM_TARGET = 1650;
  localparam int DRAIN_POINT = 1000;
  localparam int BURST_FIRST = 600;
  localparam int BURST_LAST  = 900;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  wdce_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wdce_pkg::out_item_t out_data;

  wdce_pkg::in_item_t  byte_q[$];
  wdce_pkg::out_item_t exp_results_q[$];
  logic                in_taken       = 1'b0;
  int                  sent_count     = 0;
  int                  mismatch_count = 0;
  int unsigned         cycle_count    = 0;

  logic [2:0]  wav_phase;
  logic [5:0]  byte_cnt;
  logic [2:0]  hdr_idx;
  logic [31:0] id_shift;
  logic [31:0] chunk_len;
  logic [32:0] skip_left;
  logic [31:0] data_left;
  logic [7:0]  low_byte;
  logic        low_ok;
  logic        data_seen;

  wav_data_chunk_extractor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  task automatic queue_item(input wdce_pkg::in_item_t it);
    byte_q.insert(byte_q.size(), it);
  endtask

  task automatic queue_expected(input wdce_pkg::out_item_t r);
    exp_results_q.insert(exp_results_q.size(), r);
  endtask

  task automatic append_byte(ref logic [7:0] f[$], input logic [7:0] v);
    f.insert(f.size(), v);
  endtask

  task automatic clear_parser();
    wav_phase = wdce_pkg::PH_RIFF;
    byte_cnt  = '0;
    hdr_idx   = '0;
    id_shift  = '0;
    chunk_len = '0;
    skip_left = '0;
    data_left = '0;
    low_byte  = '0;
    low_ok    = 1'b0;
    data_seen = 1'b0;
  endtask

  task automatic parse_wav_byte(input wdce_pkg::in_item_t it);
    wdce_pkg::out_item_t res[2];
    int                  n;
    n = 0;
    if (byte_cnt < wdce_pkg::MIN_FILE_BYTES) byte_cnt = byte_cnt + 1'b1;
    case (wav_phase)
      wdce_pkg::PH_RIFF: begin
        if (byte_cnt >= wdce_pkg::RIFF_HEADER_BYTES) begin
          wav_phase = wdce_pkg::PH_HEADER;
          hdr_idx   = '0;
        end
      end
      wdce_pkg::PH_HEADER: begin
        if (hdr_idx < wdce_pkg::HDR_ID_BYTES) begin
          id_shift = {id_shift[23:0], it.file_byte};
          if (hdr_idx == 3'd0) chunk_len = '0;
        end else begin
          chunk_len = chunk_len | ({24'd0, it.file_byte} << (8 * hdr_idx[1:0]));
        end
        if (hdr_idx == wdce_pkg::HDR_LAST_INDEX) begin
          hdr_idx = '0;
          if (id_shift == wdce_pkg::DATA_ID) begin
            data_seen = 1'b1;
            data_left = chunk_len;
            wav_phase = (chunk_len == 0) ? wdce_pkg::PH_DONE : wdce_pkg::PH_DATA;
          end else begin
            skip_left = {1'b0, chunk_len} + chunk_len[0];
            wav_phase = (skip_left == 0) ? wdce_pkg::PH_HEADER : wdce_pkg::PH_SKIP;
          end
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      wdce_pkg::PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 1'b1;
        if (skip_left == 0) begin
          wav_phase = wdce_pkg::PH_HEADER;
          hdr_idx   = '0;
        end
      end
      wdce_pkg::PH_DATA: begin
        if (data_left != 0) begin
          data_left = data_left - 1'b1;
          if (low_ok) begin
            res[n] = '{kind: wdce_pkg::KIND_SAMPLE, sample: {it.file_byte, low_byte},
                       last: 1'b0};
            n++;
            low_ok = 1'b0;
          end else begin
            low_byte = it.file_byte;
            low_ok   = 1'b1;
          end
        end
        if (data_left == 0) begin
          wav_phase = wdce_pkg::PH_DONE;
          low_ok    = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (it.end_of_file) begin
      res[n] = '{kind: wdce_pkg::KIND_NODATA, sample: '0, last: 1'b0};
      if (byte_cnt < wdce_pkg::MIN_FILE_BYTES) res[n].kind = wdce_pkg::KIND_SHORT;
      else if (data_seen) res[n].kind = wdce_pkg::KIND_OK;
      n++;
      clear_parser();
    end
    if (n > 0) res[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) queue_expected(res[k]);
  endtask

  task automatic add_header(ref logic [7:0] f[$], input logic [31:0] id,
                            input logic [31:0] len);
    append_byte(f, id[31:24]);
    append_byte(f, id[23:16]);
    append_byte(f, id[15:8]);
    append_byte(f, id[7:0]);
    append_byte(f, len[7:0]);
    append_byte(f, len[15:8]);
    append_byte(f, len[23:16]);
    append_byte(f, len[31:24]);
  endtask

  task automatic add_wav_file();
    logic [7:0]         f[$];
    logic [31:0]        len;
    int                 mode;
    int                 cut;
    wdce_pkg::in_item_t it;
    mode = $urandom_range(0, 9);
    repeat (12) append_byte(f, 8'($urandom));
    if (mode == 0) begin
      repeat ($urandom_range(0, 60)) append_byte(f, 8'($urandom));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        len = $urandom_range(0, 9);
        if ($urandom_range(0, 1) == 1) add_header(f, $urandom, len);
        else add_header(f, wdce_pkg::DATA_ID ^ (32'd1 << $urandom_range(0, 31)), len);
        repeat (len + len[0]) append_byte(f, 8'($urandom));
      end
      case (mode)
        1: begin
          repeat ($urandom_range(0, 20)) append_byte(f, 8'($urandom));
        end
        2: begin
          len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : $urandom;
          add_header(f, $urandom, len);
          repeat ($urandom_range(0, 30)) append_byte(f, 8'($urandom));
        end
        3: begin
          len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : $urandom;
          add_header(f, wdce_pkg::DATA_ID, len);
          repeat ($urandom_range(0, 40)) append_byte(f, 8'($urandom));
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       len = 32'd0;
            1:       len = 32'd1;
            2:       len = 2 * $urandom_range(0, 20) + 1;
            default: len = $urandom_range(2, 40);
          endcase
          add_header(f, wdce_pkg::DATA_ID, len);
          repeat (len) append_byte(f, 8'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 8)) append_byte(f, 8'($urandom));
          end
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, f.size());
      while (f.size() > cut) void'(f.pop_back());
    end
    for (int k = 0; k < f.size(); k++) begin
      it.file_byte   = f[k];
      it.end_of_file = (k == f.size() - 1);
      queue_item(it);
    end
  endtask

  function automatic bit idle_roll();
    if (sent_count >= BURST_FIRST && sent_count < BURST_LAST) return 1'b0;
    return $urandom_range(0, 99) < 35;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (byte_q.size() == 0 || idle_roll() ||
            (sent_count == DRAIN_POINT && exp_results_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_data    <= byte_q.pop_front();
          sent_count <= sent_count + 1;
        end
      end
      out_stall <= idle_roll();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_results_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected result transfer: kind %0d sample %0d last %0d",
                     out_data.kind, out_data.sample, out_data.last);
          end
        end else if (out_data.kind !== exp_results_q[0].kind ||
                     out_data.sample !== exp_results_q[0].sample ||
                     out_data.last !== exp_results_q[0].last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch (kind/sample/last): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     exp_results_q[0].kind, exp_results_q[0].sample, exp_results_q[0].last,
                     out_data.kind, out_data.sample, out_data.last);
          end
          void'(exp_results_q.pop_front());
        end else begin
          void'(exp_results_q.pop_front());
        end
      end
      if (in_valid && !in_stall) parse_wav_byte(in_data);
      in_taken <= in_valid && !in_stall;
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    wdce_pkg::in_item_t it;
    clear_parser();
    // A one-byte file, then a short file whose samples hit both extremes.
    it = '{file_byte: 8'hFF, end_of_file: 1'b1};
    queue_item(it);
    for (int k = 0; k < 12; k++) begin
      it = '{file_byte: (k[0] ? 8'hFF : 8'h00), end_of_file: 1'b0};
      queue_item(it);
    end
    for (int k = 3; k >= 0; k--) begin
      it = '{file_byte: wdce_pkg::DATA_ID[8 * k +: 8], end_of_file: 1'b0};
      queue_item(it);
    end
    it = '{file_byte: 8'h04, end_of_file: 1'b0};
    queue_item(it);
    it = '{file_byte: 8'h00, end_of_file: 1'b0};
    repeat (4) queue_item(it);
    it = '{file_byte: 8'h80, end_of_file: 1'b0};
    queue_item(it);
    it = '{file_byte: 8'hFF, end_of_file: 1'b0};
    queue_item(it);
    it = '{file_byte: 8'h7F, end_of_file: 1'b1};
    queue_item(it);
    while (byte_q.size() < ITEM_TARGET + 25) add_wav_file();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (exp_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/wdce_pkg.sv
src/wdce_parser.sv
src/wdce_result_fifo.sv
src/wav_data_chunk_extractor_top.sv
bench/wav_data_chunk_extractor_top_tb.sv
